/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Sizes
  localparam int DATA_W          = 8;
  localparam int LIMIT_W         = 16;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Register index (word select of paddr)
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  // One result slot
  typedef struct packed {
    logic              is_end;
    logic [DATA_W-1:0] data;
  } slot_t;

  // Results caused by one input item, in order; count is 1 to 3
  typedef struct packed {
    logic [1:0]      count;
    slot_t [2:0]     slot;
  } entry_t;

  // True for 0-9, A-F, a-f
  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) ||
        ((c >= 8'h41) && (c <= 8'h46)) ||
        ((c >= 8'h61) && (c <= 8'h66));
    return r;
  endfunction

  // Nibble value of a hex digit; don't care for other codes
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

/* rtl/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front
// Accepts source bytes, tracks escape state and the per-string byte count,
// and packs the results of each item into one queue entry.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [upd_pkg::DATA_W-1:0]    in_byte,
  input  logic                          end_of_string,
  input  logic [upd_pkg::LIMIT_W-1:0]   output_limit,
  input  logic                          q_full,
  output logic                          q_push,
  output upd_pkg::entry_t               q_entry
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t                        phase, phase_next;
  logic [upd_pkg::DATA_W-1:0]    held, held_next;
  logic [upd_pkg::LIMIT_W-1:0]   count, count_next;

  logic [2:0][upd_pkg::DATA_W-1:0] cand;
  logic [1:0]                    k;
  logic                          fpct;
  logic                          accept;
  logic                          fresh_is_pct;
  logic [upd_pkg::DATA_W-1:0]    fresh_byte;
  logic [upd_pkg::LIMIT_W-1:0]   room;
  logic [1:0]                    n;
  logic                          start_esc;

  assign accept       = in_valid && !q_full;
  assign in_stall     = q_full;
  assign fresh_is_pct = (in_byte == upd_pkg::CH_PERCENT);
  assign fresh_byte   = (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;

  // Candidate emissions before the limit is applied
  always_comb begin
    cand       = '0;
    k          = 2'd0;
    fpct       = 1'b0;
    phase_next = PH_IDLE;
    held_next  = '0;
    if (end_of_string) begin
      case (phase)
        PH_PCT: begin
          cand[0] = upd_pkg::CH_PERCENT;
          k       = 2'd1;
        end
        PH_DIGIT: begin
          cand[0] = upd_pkg::CH_PERCENT;
          cand[1] = held;
          k       = 2'd2;
        end
        default: begin
          k = 2'd0;
        end
      endcase
    end else begin
      case (phase)
        PH_PCT: begin
          if (upd_pkg::is_hex(in_byte)) begin
            held_next  = in_byte;
            phase_next = PH_DIGIT;
          end else begin
            cand[0] = upd_pkg::CH_PERCENT;
            if (fresh_is_pct) begin
              fpct = 1'b1;
              k    = 2'd1;
            end else begin
              cand[1] = fresh_byte;
              k       = 2'd2;
            end
          end
        end
        PH_DIGIT: begin
          if (upd_pkg::is_hex(in_byte) && upd_pkg::is_hex(held)) begin
            cand[0] = {upd_pkg::hex_val(held), upd_pkg::hex_val(in_byte)};
            k       = 2'd1;
          end else begin
            cand[0] = upd_pkg::CH_PERCENT;
            cand[1] = held;
            if (fresh_is_pct) begin
              fpct = 1'b1;
              k    = 2'd2;
            end else begin
              cand[2] = fresh_byte;
              k       = 2'd3;
            end
          end
        end
        default: begin
          if (fresh_is_pct) begin
            fpct = 1'b1;
          end else begin
            cand[0] = fresh_byte;
            k       = 2'd1;
          end
        end
      endcase
    end
  end

  // Apply the output limit: emissions are a prefix of the candidates
  assign room      = (output_limit > count) ? (output_limit - count) : '0;
  assign n         = (room >= {{(upd_pkg::LIMIT_W-2){1'b0}}, k}) ? k : room[1:0];
  assign start_esc = fpct && (room > {{(upd_pkg::LIMIT_W-2){1'b0}}, k});
  assign count_next = end_of_string ? '0 : (count + {{(upd_pkg::LIMIT_W-2){1'b0}}, n});

  // Pack the entry; the end marker follows the emitted bytes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_entry.slot[i].is_end = 1'b0;
      q_entry.slot[i].data   = cand[i];
      if (end_of_string && (n == 2'(i))) begin
        q_entry.slot[i].is_end = 1'b1;
        q_entry.slot[i].data   = '0;
      end
    end
    q_entry.count = n + {1'b0, end_of_string};
  end

  assign q_push = accept && (end_of_string || (n != 2'd0));

  // Escape state and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
      count <= '0;
    end else if (accept) begin
      phase <= start_esc ? PH_PCT : phase_next;
      held  <= start_esc ? '0 : held_next;
      count <= count_next;
    end
  end

endmodule

/* rtl/upd_queue.sv */
// ----------------------------------------------------------------------------
// upd_queue
// Small register FIFO of result entries between front and back.
// ----------------------------------------------------------------------------
module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  upd_pkg::entry_t  wr_entry,
  input  logic             pop,
  output upd_pkg::entry_t  rd_entry,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  upd_pkg::entry_t  store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_entry  = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back
// Walks the slots of the head entry and drives the output register.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  upd_pkg::entry_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [upd_pkg::DATA_W-1:0]  out_byte,
  output logic                        out_end
);

  logic [1:0] idx;
  logic       load;
  logic       last_slot;

  assign load      = !out_valid || !out_stall;
  assign last_slot = (idx == (head.count - 2'd1));
  assign pop       = load && head_valid && last_slot;

  // Slot index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= last_slot ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= head.slot[idx].data;
      out_end  <= head.slot[idx].is_end;
    end
  end

endmodule

/* rtl/url_percent_decoder_unit.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Form-urlencoded percent decoder: "%hh" to one byte, '+' to space.
// Path: an accepted request's results are written into the entry queue, then
//   read from the queue head into the output register.
// Throughput: one request per cycle while requests give at most one result and
//   out_stall is low; results of a request leave one at a time, the queue of
//   QUEUE_DEPTH entries absorbs the difference, and in_stall rises when it is full.
// Reset (rst, synchronous): escape state, count, queue and output valid clear;
//   output_limit returns to 65535.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [upd_pkg::DATA_W-1:0]      in_byte,
  input  logic                            end_of_string,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [upd_pkg::DATA_W-1:0]      out_byte,
  output logic                            out_end,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [upd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [upd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [upd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [upd_pkg::LIMIT_W-1:0] output_limit;
  logic                        q_full, q_push, q_pop, q_not_empty;
  upd_pkg::entry_t             q_wr, q_rd;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == upd_pkg::REG_OUTPUT_LIMIT) ?
                  {{(upd_pkg::APB_DATA_W-upd_pkg::LIMIT_W){1'b0}}, output_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= upd_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == upd_pkg::REG_OUTPUT_LIMIT)) begin
      output_limit <= pwdata[upd_pkg::LIMIT_W-1:0];
    end
  end

  upd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .output_limit  (output_limit),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_wr)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (q_wr),
    .pop       (q_pop),
    .rd_entry  (q_rd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (q_rd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_end    (out_end)
  );

endmodule

/* rtl/upd_checker.sv */
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [upd_pkg::DATA_W-1:0]      out_byte,
  input logic                            out_end,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [upd_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [upd_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [upd_pkg::APB_DATA_W-1:0]  prdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_end))
    else $error("stalled result changed");

  // End marker carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |-> out_byte == '0)
    else $error("end marker with nonzero byte");

  // Reset empties the output
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Limit write reads back
  a_limit_rb: assert property (@(posedge clk)
    psel && penable && pwrite && !rst && (paddr[2] == upd_pkg::REG_OUTPUT_LIMIT)
    |=> rst || (paddr[2] != upd_pkg::REG_OUTPUT_LIMIT) ||
        (prdata[upd_pkg::LIMIT_W-1:0] == $past(pwdata[upd_pkg::LIMIT_W-1:0])))
    else $error("limit readback mismatch");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_end   (out_end),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
